/* rtl/bfe_pkg.sv */
package bfe_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_WORDS   = 1024;
  localparam int unsigned DEF_PROBE_COUNT = 7;

  // Field widths.
  localparam int unsigned FW_W    = 11;        // filter_words register
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned Q_W     = FW_W + 6;  // bit position inside the words in use

  // Remainder unit: dividend width and bits retired per cycle.
  localparam int unsigned DIVD_W   = 60;
  localparam int unsigned DIV_STEP = 4;
  localparam int unsigned DIV_CYC  = DIVD_W / DIV_STEP;

  localparam logic [FW_W-1:0]    FW_RESET  = 11'd1024;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 17'h1FFFF;

  localparam logic [63:0] MIX_MUL_A   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] GOLDEN_SEED = 64'h9e3779b97f4a7c15;
  localparam int unsigned MIX_SHIFT   = 33;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_COUNT = 2'd3
  } mode_t;

  // Which value goes through the remainder unit.
  typedef enum logic [1:0] {
    MSRC_H1   = 2'd0,
    MSRC_H2   = 2'd1,
    MSRC_WRAP = 2'd2
  } msrc_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_H_PRE,
    S_H_M1,
    S_H_W1,
    S_H_MIX,
    S_H_M2,
    S_H_W2,
    S_H_END,
    S_M_GO,
    S_M_WAIT,
    S_P_RD,
    S_P_UPD,
    S_CLR,
    S_CNT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  cap;          // take the request and its key
    logic  init_wr;      // zero one word of the post-reset sweep
    logic  clr_wr;       // zero one word of a clear request
    logic  cnt_step;     // one step of the population count
    logic  v_load;       // first xor-shift of a hash input
    logic  v_mix;        // xor-shift between the two multiplies
    logic  hsel;         // 0 works on h1, 1 on h2
    logic  mul_start;
    logic  mul_const_b;  // second finalizer constant
    logic  hash_store;
    logic  mod_start;
    msrc_t mod_sel;
    logic  mod_store;
    logic  probe_rd;
    logic  probe_upd;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  mul_done;
    logic  mod_done;
    logic  init_last;
    logic  clr_last;
    logic  cnt_done;
    logic  out_free;
  } stat_t;

  function automatic logic [63:0] xor_shift(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

  // Keeps the bytes of one key half whose index lies below the key length.
  function automatic logic [63:0] key_bytes(input logic [63:0] k,
                                            input logic [LEN_W-1:0] len,
                                            input logic [LEN_W-1:0] base);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if ((base + LEN_W'(i)) < len) begin
        r[i*8 +: 8] = k[i*8 +: 8];
      end
    end
    return r;
  endfunction

endpackage

/* rtl/bfe_mul64.sv */
module bfe_mul64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  // Low 64 bits of a*b from three 32x32 partial products, one per cycle.
  logic        busy;
  logic [1:0]  step;
  logic [63:0] a_r, b_r, mr, acc;
  logic [31:0] mx, my;
  logic [63:0] prod;

  always_comb begin
    case (step)
      2'd0: begin
        mx = a_r[31:0];
        my = b_r[31:0];
      end
      2'd1: begin
        mx = a_r[31:0];
        my = b_r[63:32];
      end
      default: begin
        mx = a_r[63:32];
        my = b_r[31:0];
      end
    endcase
  end

  assign prod = mx * my;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      mr <= prod;
      case (step)
        2'd0: acc <= acc;
        2'd1: acc <= mr;
        default: acc <= acc + {mr[31:0], 32'b0};
      endcase
    end
  end

  assign p = acc;

endmodule

/* rtl/bfe_mod.sv */
module bfe_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bfe_pkg::DIVD_W-1:0]  dividend,
  input  logic [bfe_pkg::FW_W-1:0]    divisor,
  output logic                        done,
  output logic [bfe_pkg::FW_W-1:0]    rem
);

  // Restoring remainder, four dividend bits per cycle.
  localparam int unsigned FW = bfe_pkg::FW_W;
  localparam int unsigned SW = $clog2(bfe_pkg::DIV_CYC);

  logic                       busy;
  logic [SW-1:0]              step;
  logic [bfe_pkg::DIVD_W-1:0] dvd;
  logic [FW-1:0]              div_r;
  logic [FW-1:0]              rem_next;

  always_comb begin
    logic [FW:0] t;
    rem_next = rem;
    for (int j = 0; j < bfe_pkg::DIV_STEP; j++) begin
      t = {rem_next, dvd[bfe_pkg::DIVD_W-1-j]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      rem_next = t[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + SW'(1);
        if (step == SW'(bfe_pkg::DIV_CYC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      div_r <= divisor;
      rem   <= '0;
    end else if (busy) begin
      dvd <= dvd << bfe_pkg::DIV_STEP;
      rem <= rem_next;
    end
  end

endmodule

/* rtl/bfe_datapath.sv */
module bfe_datapath #(
  parameter int unsigned MAX_WORDS = bfe_pkg::DEF_MAX_WORDS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bfe_pkg::cmd_t               cmd,
  output bfe_pkg::stat_t              stat,
  input  logic [1:0]                  mode,
  input  logic [63:0]                 key_low,
  input  logic [63:0]                 key_high,
  input  logic [bfe_pkg::LEN_W-1:0]   key_length,
  input  logic                        cfg_wr_en,
  input  logic [bfe_pkg::FW_W-1:0]    cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        maybe_present,
  output logic [bfe_pkg::TOTAL_W-1:0] set_bit_total
);

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam int unsigned FW = bfe_pkg::FW_W;
  localparam int unsigned QW = bfe_pkg::Q_W;
  localparam int unsigned TW = bfe_pkg::TOTAL_W;

  localparam logic [bfe_pkg::LEN_W-1:0] LEN_W0 = '0;
  localparam logic [bfe_pkg::LEN_W-1:0] LEN_W8 = 5'd8;

  logic [FW-1:0]    fw;
  logic [FW-1:0]    w_eff;
  logic [FW-1:0]    w;
  bfe_pkg::mode_t   mode_r;
  logic [63:0]      ka, kb;
  logic [63:0]      v, pv, h2;
  logic [QW-1:0]    q, r2, rr;
  logic [CW-1:0]    cnt;
  logic             pend;
  logic [TW-1:0]    total;
  logic             all_ok;
  logic [63:0]      rd_data;
  logic [63:0]      mem [MAX_WORDS];

  logic             mul_done, mod_done;
  logic [63:0]      mul_p;
  logic [FW-1:0]    mod_rem;
  logic [bfe_pkg::DIVD_W-1:0] mod_dvd;
  logic [63:0]      mix_out;
  logic [63:0]      mask;
  logic [AW-1:0]    qword;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [63:0]      wdata;
  logic [QW-1:0]    nbits;
  logic [QW:0]      sum;
  logic [QW-1:0]    sum_red, q_next;
  logic [64:0]      pv_sum;
  logic [TW:0]      tot_sum;

  // Word count clamp: zero acts as one, oversize acts as the store depth.
  always_comb begin
    if (fw == '0) begin
      w_eff = FW'(1);
    end else if (32'(fw) > 32'(MAX_WORDS)) begin
      w_eff = FW'(MAX_WORDS);
    end else begin
      w_eff = fw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= bfe_pkg::FW_RESET;
    end else if (cfg_wr_en) begin
      fw <= cfg_wr_data;
    end
  end

  assign mix_out = bfe_pkg::xor_shift(mul_p);

  bfe_mul64 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (v),
    .b     (cmd.mul_const_b ? bfe_pkg::MIX_MUL_B : bfe_pkg::MIX_MUL_A),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    case (cmd.mod_sel)
      bfe_pkg::MSRC_H1:   mod_dvd = bfe_pkg::DIVD_W'(pv >> 6);
      bfe_pkg::MSRC_H2:   mod_dvd = bfe_pkg::DIVD_W'(h2 >> 6);
      default:            mod_dvd = bfe_pkg::DIVD_W'(1) << 58;
    endcase
  end

  bfe_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (w),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Next probe position: (q + h2 mod N), less 2^64 mod N when the 64-bit sum wraps.
  assign nbits  = {w, 6'b0};
  assign sum    = {1'b0, q} + {1'b0, r2};
  assign sum_red = (sum >= {1'b0, nbits}) ? QW'(sum - {1'b0, nbits}) : sum[QW-1:0];
  assign pv_sum = {1'b0, pv} + {1'b0, h2};
  always_comb begin
    if (!pv_sum[64]) begin
      q_next = sum_red;
    end else if (sum_red >= rr) begin
      q_next = sum_red - rr;
    end else begin
      q_next = sum_red + nbits - rr;
    end
  end

  assign qword = AW'(q[QW-1:6]);
  assign mask  = 64'd1 << q[5:0];

  always_comb begin
    we    = 1'b0;
    waddr = cnt[AW-1:0];
    wdata = '0;
    if (cmd.init_wr || cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.probe_upd && mode_r == bfe_pkg::MODE_ADD) begin
      we    = 1'b1;
      waddr = qword;
      wdata = rd_data | mask;
    end
    re    = cmd.probe_rd || (cmd.cnt_step && cnt != CW'(w));
    raddr = cmd.probe_rd ? qword : cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  assign tot_sum = {1'b0, total} + (TW + 1)'($countones(rd_data));

  // Sweep counter and count pipeline flag are control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cmd.cap) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cmd.init_wr || cmd.clr_wr) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.cnt_step) begin
      if (cnt != CW'(w)) begin
        cnt  <= cnt + CW'(1);
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r <= bfe_pkg::mode_t'(mode);
      ka     <= bfe_pkg::key_bytes(key_low, key_length, LEN_W0);
      kb     <= bfe_pkg::key_bytes(key_high, key_length, LEN_W8);
      w      <= w_eff;
      total  <= '0;
      all_ok <= 1'b1;
    end
    if (cmd.v_load) begin
      v <= bfe_pkg::xor_shift(cmd.hsel ? (kb ^ bfe_pkg::GOLDEN_SEED) : ka);
    end
    if (cmd.v_mix) begin
      v <= mix_out;
    end
    if (cmd.hash_store) begin
      if (cmd.hsel) begin
        h2 <= mix_out;
      end else begin
        pv <= mix_out;
      end
    end
    if (cmd.mod_store) begin
      case (cmd.mod_sel)
        bfe_pkg::MSRC_H1: q  <= {mod_rem, pv[5:0]};
        bfe_pkg::MSRC_H2: r2 <= {mod_rem, h2[5:0]};
        default:          rr <= {mod_rem, 6'b0};
      endcase
    end
    if (cmd.probe_upd) begin
      if (mode_r == bfe_pkg::MODE_QUERY && (rd_data & mask) == '0) begin
        all_ok <= 1'b0;
      end
      pv <= pv_sum[63:0];
      q  <= q_next;
    end
    if (cmd.cnt_step && pend) begin
      total <= (tot_sum > {1'b0, bfe_pkg::TOTAL_MAX}) ? bfe_pkg::TOTAL_MAX : tot_sum[TW-1:0];
    end
    if (cmd.out_load) begin
      maybe_present <= (mode_r == bfe_pkg::MODE_QUERY) && all_ok;
      set_bit_total <= (mode_r == bfe_pkg::MODE_COUNT) ? total : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.mode      = mode_r;
    stat.mul_done  = mul_done;
    stat.mod_done  = mod_done;
    stat.init_last = (cnt == CW'(MAX_WORDS - 1));
    stat.clr_last  = (cnt == CW'(w - FW'(1)));
    stat.cnt_done  = (cnt == CW'(w)) && !pend;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

/* rtl/bfe_ctrl.sv */
module bfe_ctrl #(
  parameter int unsigned PROBE_COUNT = bfe_pkg::DEF_PROBE_COUNT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bfe_pkg::stat_t stat,
  output bfe_pkg::cmd_t  cmd
);

  localparam int unsigned PW = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;

  bfe_pkg::state_t state, state_next;
  logic            hsel, hsel_next;
  bfe_pkg::msrc_t  msel, msel_next;
  logic [PW-1:0]   pc, pc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfe_pkg::S_INIT;
      hsel  <= 1'b0;
      msel  <= bfe_pkg::MSRC_H1;
      pc    <= '0;
    end else begin
      state <= state_next;
      hsel  <= hsel_next;
      msel  <= msel_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    state_next = state;
    hsel_next  = hsel;
    msel_next  = msel;
    pc_next    = pc;
    cmd        = '0;
    cmd.hsel    = hsel;
    cmd.mod_sel = msel;
    in_ready   = 1'b0;
    case (state)
      bfe_pkg::S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) begin
          state_next = bfe_pkg::S_IDLE;
        end
      end
      bfe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          hsel_next = 1'b0;
          msel_next = bfe_pkg::MSRC_H1;
          pc_next   = '0;
          state_next = bfe_pkg::S_H_PRE;
        end
      end
      bfe_pkg::S_H_PRE: begin
        // Clear and count branch off here, after the request is captured.
        if (stat.mode == bfe_pkg::MODE_CLEAR) begin
          state_next = bfe_pkg::S_CLR;
        end else if (stat.mode == bfe_pkg::MODE_COUNT) begin
          state_next = bfe_pkg::S_CNT;
        end else begin
          cmd.v_load = 1'b1;
          state_next = bfe_pkg::S_H_M1;
        end
      end
      bfe_pkg::S_H_M1: begin
        cmd.mul_start = 1'b1;
        state_next    = bfe_pkg::S_H_W1;
      end
      bfe_pkg::S_H_W1: begin
        if (stat.mul_done) begin
          state_next = bfe_pkg::S_H_MIX;
        end
      end
      bfe_pkg::S_H_MIX: begin
        cmd.v_mix  = 1'b1;
        state_next = bfe_pkg::S_H_M2;
      end
      bfe_pkg::S_H_M2: begin
        cmd.mul_start   = 1'b1;
        cmd.mul_const_b = 1'b1;
        state_next      = bfe_pkg::S_H_W2;
      end
      bfe_pkg::S_H_W2: begin
        if (stat.mul_done) begin
          state_next = bfe_pkg::S_H_END;
        end
      end
      bfe_pkg::S_H_END: begin
        cmd.hash_store = 1'b1;
        if (hsel) begin
          state_next = bfe_pkg::S_M_GO;
        end else begin
          hsel_next  = 1'b1;
          state_next = bfe_pkg::S_H_PRE;
        end
      end
      bfe_pkg::S_M_GO: begin
        cmd.mod_start = 1'b1;
        state_next    = bfe_pkg::S_M_WAIT;
      end
      bfe_pkg::S_M_WAIT: begin
        if (stat.mod_done) begin
          cmd.mod_store = 1'b1;
          case (msel)
            bfe_pkg::MSRC_H1: begin
              msel_next  = bfe_pkg::MSRC_H2;
              state_next = bfe_pkg::S_M_GO;
            end
            bfe_pkg::MSRC_H2: begin
              msel_next  = bfe_pkg::MSRC_WRAP;
              state_next = bfe_pkg::S_M_GO;
            end
            default: begin
              state_next = bfe_pkg::S_P_RD;
            end
          endcase
        end
      end
      bfe_pkg::S_P_RD: begin
        cmd.probe_rd = 1'b1;
        state_next   = bfe_pkg::S_P_UPD;
      end
      bfe_pkg::S_P_UPD: begin
        cmd.probe_upd = 1'b1;
        if (pc == PW'(PROBE_COUNT - 1)) begin
          state_next = bfe_pkg::S_DONE;
        end else begin
          pc_next    = pc + PW'(1);
          state_next = bfe_pkg::S_P_RD;
        end
      end
      bfe_pkg::S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = bfe_pkg::S_DONE;
        end
      end
      bfe_pkg::S_CNT: begin
        cmd.cnt_step = 1'b1;
        if (stat.cnt_done) begin
          state_next = bfe_pkg::S_DONE;
        end
      end
      bfe_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bfe_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bfe_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bloom_filter_engine.sv */
// Bloom filter engine with double hashing. Each request carries a mode (add,
// query, clear, count) and a key of up to 16 bytes; exactly one result comes
// back per request, with maybe_present set for a query whose probed bits are
// all set and set_bit_total carrying the population count for a count
// request. The bit store is MAX_WORDS words of 64 bits in a single-port
// style memory; filter_words selects how many words are in use. The user
// must write it through cfg_wr_en/cfg_wr_data only while the engine is
// idle; the block itself does not enforce this. After reset the engine
// zeroes the whole store, one word per cycle, and holds in_ready low during
// that sweep. Requests are handled one at a time. For an add or query, the
// two 64-bit finalizer hashes run four multiplies through one shared 32x32
// multiplier with the xor-shifts between them, the three remainders
// modulo the bit count run through a radix-16 remainder unit, each of
// the PROBE_COUNT probes costs a memory read and an update step, and the
// result is then loaded. With W the number of words in use, a clear
// writes and a count reads each of the W words, both paced by the one
// memory port. The engine goes back to idle between requests, so it
// takes no new request until the last one's result is loaded. A finished
// result sits in an output register, so the next request is taken while
// it waits.
module bloom_filter_engine #(
  parameter int unsigned MAX_WORDS   = bfe_pkg::DEF_MAX_WORDS,
  parameter int unsigned PROBE_COUNT = bfe_pkg::DEF_PROBE_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [63:0]                 key_low,
  input  logic [63:0]                 key_high,
  input  logic [bfe_pkg::LEN_W-1:0]   key_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        maybe_present,
  output logic [bfe_pkg::TOTAL_W-1:0] set_bit_total,
  input  logic                        cfg_wr_en,
  input  logic [bfe_pkg::FW_W-1:0]    cfg_wr_data
);

  // The controller sequences the work; the datapath holds the key, hashes,
  // probe position, store and result register.
  bfe_pkg::cmd_t  cmd;
  bfe_pkg::stat_t stat;

  bfe_ctrl #(
    .PROBE_COUNT (PROBE_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfe_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .key_low       (key_low),
    .key_high      (key_high),
    .key_length    (key_length),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .maybe_present (maybe_present),
    .set_bit_total (set_bit_total)
  );

endmodule

/* tb/sv/tb_bloom_filter_engine.sv */
module tb_bloom_filter_engine;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORDS_MAX = bfe_pkg::DEF_MAX_WORDS;
  localparam int unsigned PROBES    = bfe_pkg::DEF_PROBE_COUNT;
  localparam int unsigned LEN_W     = bfe_pkg::LEN_W;
  localparam int unsigned TOTAL_W   = bfe_pkg::TOTAL_W;
  localparam int unsigned FW_W      = bfe_pkg::FW_W;

  // A count over the full store is the slowest request, so the final settle
  // wait is sized from it with some margin.
  localparam int unsigned SETTLE_CYCLES = WORDS_MAX + 200;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         mode;
  logic [63:0]        key_low;
  logic [63:0]        key_high;
  logic [LEN_W-1:0]   key_length;
  logic               out_valid;
  logic               out_ready;
  logic               maybe_present;
  logic [TOTAL_W-1:0] set_bit_total;
  logic               cfg_wr_en;
  logic [FW_W-1:0]    cfg_wr_data;

  bloom_filter_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .key_low      (key_low),
    .key_high     (key_high),
    .key_length   (key_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .maybe_present(maybe_present),
    .set_bit_total(set_bit_total),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // One expected result per request.
  typedef struct {
    logic               present;
    logic [TOTAL_W-1:0] total;
  } lookup_result_t;

  lookup_result_t pending_results[$];

  // Shadow copy of the filter: the bit store and the word-count register.
  logic [63:0]     shadow_store[WORDS_MAX];
  logic [FW_W-1:0] shadow_words;

  int unsigned mismatches;
  bit          stalls_on;

  // Recently added keys, so that queries can hit as well as miss.
  logic [63:0] pool_low[$];
  logic [63:0] pool_high[$];
  logic [4:0]  pool_len[$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [63:0] finalize64(input logic [63:0] v);
    logic [63:0] x;
    x = v ^ (v >> bfe_pkg::MIX_SHIFT);
    x = x * 64'hff51afd7ed558ccd;
    x = x ^ (x >> bfe_pkg::MIX_SHIFT);
    x = x * 64'hc4ceb9fe1a85ec53;
    return x ^ (x >> bfe_pkg::MIX_SHIFT);
  endfunction

  function automatic int unsigned active_words();
    if (shadow_words == '0) begin
      return 1;
    end
    if (shadow_words > WORDS_MAX) begin
      return WORDS_MAX;
    end
    return shadow_words;
  endfunction

  // Works out the result of one request and applies its effect on the
  // shadow store. Bytes at or past the key length read as zero, and a
  // length above 16 is clipped to 16.
  function automatic lookup_result_t apply_request(input logic [1:0] m,
                                                   input logic [63:0] klo,
                                                   input logic [63:0] khi,
                                                   input logic [4:0] klen);
    lookup_result_t r;
    int unsigned    len;
    int unsigned    nwords;
    logic [63:0]    a;
    logic [63:0]    b;
    logic [63:0]    h1;
    logic [63:0]    h2;
    logic [63:0]    pos;
    logic [63:0]    nbits;
    bit             all_set;
    int unsigned    ones;
    r.present = 1'b0;
    r.total   = '0;
    len       = (klen > 16) ? 16 : klen;
    nwords    = active_words();
    nbits     = 64'(nwords) * 64;
    case (m)
      bfe_pkg::MODE_ADD, bfe_pkg::MODE_QUERY: begin
        a = '0;
        b = '0;
        for (int i = 0; i < 8; i++) begin
          if (i < len) a[i*8 +: 8] = klo[i*8 +: 8];
          if (i + 8 < len) b[i*8 +: 8] = khi[i*8 +: 8];
        end
        h1 = finalize64(a);
        h2 = finalize64(b ^ 64'h9e3779b97f4a7c15);
        all_set = 1'b1;
        for (int i = 0; i < PROBES; i++) begin
          pos = (h1 + 64'(i) * h2) % nbits;
          if (m == bfe_pkg::MODE_ADD) begin
            shadow_store[pos[15:6]][pos[5:0]] = 1'b1;
          end else if (!shadow_store[pos[15:6]][pos[5:0]]) begin
            all_set = 1'b0;
          end
        end
        if (m == bfe_pkg::MODE_QUERY) r.present = all_set;
      end
      bfe_pkg::MODE_CLEAR: begin
        for (int w = 0; w < nwords; w++) shadow_store[w] = '0;
      end
      default: begin
        ones = 0;
        for (int w = 0; w < nwords; w++) ones += $countones(shadow_store[w]);
        r.total = (ones > bfe_pkg::TOTAL_MAX) ? bfe_pkg::TOTAL_MAX : ones[TOTAL_W-1:0];
      end
    endcase
    return r;
  endfunction

  // Result checker: every accepted result is matched against the oldest
  // expectation. Sampling at the rising edge sees the pre-edge values.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (maybe_present !== want.present) begin
          $error("maybe_present: expected %0d, got %0d", want.present, maybe_present);
          mismatches++;
        end
        if (set_bit_total !== want.total) begin
          $error("set_bit_total: expected %0d, got %0d", want.total, set_bit_total);
          mismatches++;
        end
      end
    end
  end

  // Receiver side: random bursts of back-pressure while stalls are on.
  initial begin
    int unsigned n;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // Sends one request. It is called at a falling edge and lowers valid at
  // the falling edge after it is taken; with stalls on it may then pause.
  task automatic send_request(input logic [1:0] m, input logic [63:0] klo,
                              input logic [63:0] khi, input logic [4:0] klen);
    int unsigned gap;
    mode       = m;
    key_low    = klo;
    key_high   = khi;
    key_length = klen;
    in_valid   = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(m, klo, khi, klen));
    @(negedge clk);
    in_valid = 1'b0;
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Holds off until every expected result is back and the engine has had
  // time to settle, so that the register may be written.
  task automatic drain_and_settle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_filter_words(input logic [FW_W-1:0] value);
    drain_and_settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    shadow_words = value;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_key(input logic [63:0] klo, input logic [63:0] khi,
                         input logic [4:0] klen);
    send_request(bfe_pkg::MODE_ADD, klo, khi, klen);
    pool_low.push_back(klo);
    pool_high.push_back(khi);
    pool_len.push_back(klen);
    if (pool_low.size() > 32) begin
      void'(pool_low.pop_front());
      void'(pool_high.pop_front());
      void'(pool_len.pop_front());
    end
  endtask

  // Key extremes, the length boundaries around each half, the long-key
  // clip, and all four modes at the reset word count.
  task automatic test_directed();
    add_key('0, '0, 5'd0);
    send_request(bfe_pkg::MODE_QUERY, '0, '0, 5'd0);
    send_request(bfe_pkg::MODE_QUERY, '1, '1, 5'd0);
    add_key('1, '1, 5'd16);
    send_request(bfe_pkg::MODE_QUERY, '1, '1, 5'd16);
    send_request(bfe_pkg::MODE_QUERY, '1, '1, 5'd31);
    add_key('1, '1, 5'd8);
    send_request(bfe_pkg::MODE_QUERY, '1, '0, 5'd8);
    add_key('1, '1, 5'd9);
    send_request(bfe_pkg::MODE_QUERY, '1, 64'hff, 5'd9);
    add_key(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd7);
    send_request(bfe_pkg::MODE_QUERY, 64'h0023456789abcdef, '0, 5'd7);
    add_key(64'h8000000000000001, 64'h8000000000000001, 5'd17);
    send_request(bfe_pkg::MODE_QUERY, 64'h8000000000000001, 64'h8000000000000001, 5'd16);
    send_request(bfe_pkg::MODE_COUNT, '0, '0, 5'd0);
    send_request(bfe_pkg::MODE_CLEAR, '0, '0, 5'd0);
    send_request(bfe_pkg::MODE_COUNT, '0, '0, 5'd0);
    send_request(bfe_pkg::MODE_QUERY, '1, '1, 5'd16);
  endtask

  // Word-count extremes: zero acts as one word, anything above the
  // maximum acts as the maximum, and a resize leaves the store alone.
  task automatic test_word_count_extremes();
    write_filter_words('0);
    for (int i = 0; i < 6; i++) add_key(rand64(), rand64(), 5'($urandom_range(0, 16)));
    send_request(bfe_pkg::MODE_COUNT, '0, '0, 5'd0);
    write_filter_words(11'd2047);
    send_request(bfe_pkg::MODE_COUNT, '0, '0, 5'd0);
    add_key(rand64(), rand64(), 5'd16);
    write_filter_words(11'd1);
    send_request(bfe_pkg::MODE_QUERY, pool_low[$], pool_high[$], pool_len[$]);
    send_request(bfe_pkg::MODE_CLEAR, '0, '0, 5'd0);
    write_filter_words(11'd1024);
    send_request(bfe_pkg::MODE_COUNT, '0, '0, 5'd0);
  endtask

  // One burst of random traffic at the current word count. Most requests
  // are adds followed by queries of known keys; clears and counts are
  // rare, and with big set counts grow more common and clears rarer.
  task automatic test_random_traffic(input int unsigned count, input bit big);
    int unsigned pick;
    int unsigned idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        add_key(rand64(), rand64(), 5'($urandom_range(0, 31)));
      end else if (pick < 65 && pool_low.size() != 0) begin
        idx = $urandom_range(0, pool_low.size() - 1);
        send_request(bfe_pkg::MODE_QUERY, pool_low[idx], pool_high[idx], pool_len[idx]);
      end else if (pick < 94) begin
        send_request(bfe_pkg::MODE_QUERY, rand64(), rand64(), 5'($urandom_range(0, 31)));
      end else if (pick < 97 || (big && pick < 99)) begin
        send_request(bfe_pkg::MODE_COUNT, rand64(), rand64(), 5'($urandom));
      end else begin
        send_request(bfe_pkg::MODE_CLEAR, rand64(), rand64(), 5'($urandom));
      end
    end
  endtask

  task automatic test_random_phases();
    write_filter_words(11'd3);
    test_random_traffic(300, 1'b0);
    write_filter_words(11'd1);
    test_random_traffic(200, 1'b0);
    write_filter_words(11'($urandom_range(2, 64)));
    test_random_traffic(400, 1'b0);
    // The sender holds off here until the engine has nothing outstanding.
    drain_and_settle();
    write_filter_words(11'd1024);
    test_random_traffic(150, 1'b1);
    write_filter_words(11'($urandom_range(1, 2047)));
    test_random_traffic(80, 1'b1);
    write_filter_words(11'($urandom_range(4, 32)));
    test_random_traffic(450, 1'b0);
  endtask

  // Final stretch with no idling on either side.
  task automatic test_full_rate();
    drain_and_settle();
    stalls_on = 1'b0;
    write_filter_words(11'd2);
    test_random_traffic(300, 1'b0);
  endtask

  initial begin
    int unsigned waited;
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = bfe_pkg::MODE_ADD;
    key_low     = '0;
    key_high    = '0;
    key_length  = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    mismatches  = 0;
    stalls_on   = 1'b1;
    for (int w = 0; w < WORDS_MAX; w++) shadow_store[w] = '0;
    shadow_words = bfe_pkg::FW_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The store is swept clean after reset; requests wait for it.
    while (!in_ready) @(negedge clk);

    test_directed();
    test_word_count_extremes();
    test_random_phases();
    test_full_rate();

    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
